### hw/rtl/ihex_pkg.sv
// Shared types, codes and the nibble decode function for the hex record parser.
`timescale 1ns / 1ps

package ihex_pkg;

  // Field phase of the record state machine
  typedef enum logic [2:0] {
    PH_LINE = 3'd0,
    PH_LEN  = 3'd1,
    PH_ADDR = 3'd2,
    PH_TYPE = 3'd3,
    PH_PAGE = 3'd4,
    PH_DATA = 3'd5,
    PH_CSUM = 3'd6,
    PH_TAIL = 3'd7
  } phase_t;

  // Result kinds as carried on the master tuser
  typedef enum logic [2:0] {
    KIND_WRITE  = 3'd0,
    KIND_OK     = 3'd1,
    KIND_EOF    = 3'd2,
    KIND_RETRY  = 3'd3,
    KIND_CSUM   = 3'd4,
    KIND_FORMAT = 3'd5
  } kind_t;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_ALPHA   = 8'd55;  // 'A' - 10
  localparam logic [7:0] CASE_MASK    = 8'hDF;  // clears 'a' - 'A'
  localparam logic [7:0] REC_TYPE_PAGE = 8'h04;

  // One classified character, front to back
  typedef struct packed {
    logic       restart;
    logic       newline;
    logic [7:0] nibble;   // decoded value, modulo 256
  } item_t;

  // One result item, back to output
  typedef struct packed {
    kind_t       kind;
    logic [31:0] address;
    logic [7:0]  data;
    logic [31:0] byte_count;
  } result_t;

  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] folded;
    folded = c & CASE_MASK;
    if (c <= CHAR_NINE) begin
      return c - CHAR_ZERO;
    end
    return folded - CHAR_ALPHA;
  endfunction

endpackage

### hw/rtl/ihex_front.sv
// Front end: takes characters, classifies them and decodes the nibble value.
`timescale 1ns / 1ps

module ihex_front (
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,
  input  logic [0:0]    s_tuser,
  input  logic          q_full,
  output logic          q_push,
  output ihex_pkg::item_t q_item
);
  import ihex_pkg::*;

  assign s_tready = ~q_full;
  assign q_push   = s_tvalid & ~q_full;

  always_comb begin
    q_item.restart = s_tuser[0];
    q_item.newline = (s_tdata == CHAR_NEWLINE);
    q_item.nibble  = hex_value(s_tdata);
  end

endmodule

### hw/rtl/ihex_fifo.sv
// Short queue of classified characters between front and back.
`timescale 1ns / 1ps

module ihex_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ihex_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output ihex_pkg::item_t head,
  output logic            empty
);
  import ihex_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  item_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == FULL_COUNT);
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/ihex_back.sv
// Back end: record state machine, checksum, address build and output register.
`timescale 1ns / 1ps

module ihex_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              word_format,
  input  logic              q_empty,
  input  ihex_pkg::item_t   q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output ihex_pkg::result_t out_res
);
  import ihex_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  high_nibble, high_nibble_next;
  logic        toggle, toggle_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [8:0]  rec_len, rec_len_next;
  logic [16:0] rec_off, rec_off_next;
  logic [8:0]  field_index, field_index_next;
  logic [15:0] page_bits, page_bits_next;
  logic        linear_mode, linear_mode_next;
  logic [31:0] total_bytes, total_bytes_next;
  logic        stopped, stopped_next;

  logic        res_fire;
  result_t     res;

  logic [7:0]  byte_val;
  logic [7:0]  sum_new;
  logic [16:0] off_joined;
  logic [17:0] off_sum;
  logic [17:0] off_flip;
  logic [8:0]  fi_inc;

  // Stall only when a result waits and the sink holds it
  assign q_pop = ~q_empty & (~out_valid | out_ready);

  assign byte_val   = high_nibble | q_head.nibble;
  assign sum_new    = running_sum + byte_val;
  assign off_joined = {1'b0, rec_off[15:8], byte_val};
  assign off_sum    = {1'b0, rec_off} + {9'b0, field_index};
  assign off_flip   = off_sum ^ {17'b0, word_format};
  assign fi_inc     = field_index + 9'd1;

  always_comb begin
    phase_next       = phase;
    high_nibble_next = high_nibble;
    toggle_next      = toggle;
    running_sum_next = running_sum;
    rec_len_next     = rec_len;
    rec_off_next     = rec_off;
    field_index_next = field_index;
    page_bits_next   = page_bits;
    linear_mode_next = linear_mode;
    total_bytes_next = total_bytes;
    stopped_next     = stopped;
    res_fire         = 1'b0;
    res.kind         = KIND_OK;
    res.address      = '0;
    res.data         = '0;
    res.byte_count   = total_bytes;

    if (q_head.restart) begin
      phase_next       = PH_LINE;
      high_nibble_next = '0;
      toggle_next      = 1'b0;
      running_sum_next = '0;
      rec_len_next     = '0;
      rec_off_next     = '0;
      field_index_next = '0;
      page_bits_next   = '0;
      linear_mode_next = 1'b0;
      total_bytes_next = '0;
      stopped_next     = 1'b0;
    end else if (stopped) begin
      // ignore everything until restart
    end else if (q_head.newline) begin
      if (phase == PH_LINE || phase == PH_TAIL) begin
        phase_next = PH_LINE;
      end else begin
        stopped_next = 1'b1;
        res_fire     = 1'b1;
        res.kind     = KIND_FORMAT;
      end
    end else if (phase == PH_LINE) begin
      // start code of the line is skipped
      phase_next       = PH_LEN;
      running_sum_next = '0;
      toggle_next      = 1'b0;
    end else if (phase == PH_TAIL) begin
      // trailing text up to newline
    end else if (!toggle) begin
      high_nibble_next = {q_head.nibble[3:0], 4'b0};
      toggle_next      = 1'b1;
    end else begin
      toggle_next      = 1'b0;
      running_sum_next = sum_new;
      unique case (phase)
        PH_LEN: begin
          if (byte_val == 8'd0) begin
            stopped_next = 1'b1;
            res_fire     = 1'b1;
            res.kind     = KIND_EOF;
          end else begin
            rec_len_next     = {1'b0, byte_val};
            field_index_next = '0;
            phase_next       = PH_ADDR;
          end
        end
        PH_ADDR: begin
          if (field_index == 9'd0) begin
            rec_off_next     = {1'b0, byte_val, 8'b0};
            field_index_next = 9'd1;
          end else begin
            if (word_format) begin
              rec_off_next = {off_joined[15:0], 1'b0};
              rec_len_next = {rec_len[7:0], 1'b0};
            end else begin
              rec_off_next = off_joined;
            end
            phase_next = PH_TYPE;
          end
        end
        PH_TYPE: begin
          field_index_next = '0;
          if (byte_val == REC_TYPE_PAGE) begin
            if (word_format) begin
              stopped_next = 1'b1;
              res_fire     = 1'b1;
              res.kind     = KIND_FORMAT;
            end else begin
              phase_next = PH_PAGE;
            end
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_PAGE: begin
          if (field_index == 9'd0) begin
            page_bits_next   = {byte_val, 8'b0};
            field_index_next = 9'd1;
          end else begin
            page_bits_next   = {page_bits[15:8], byte_val};
            linear_mode_next = 1'b1;
            phase_next       = PH_CSUM;
          end
        end
        PH_DATA: begin
          total_bytes_next = total_bytes + 32'd1;
          field_index_next = fi_inc;
          if (fi_inc >= rec_len) begin
            phase_next = PH_CSUM;
          end
          res_fire       = 1'b1;
          res.kind       = KIND_WRITE;
          res.address    = {page_bits, 16'b0} | {14'b0, off_flip};
          res.data       = byte_val;
          res.byte_count = total_bytes + 32'd1;
        end
        PH_CSUM: begin
          phase_next = PH_TAIL;
          res_fire   = 1'b1;
          if (sum_new == 8'd0) begin
            res.kind = KIND_OK;
          end else begin
            stopped_next = 1'b1;
            res.kind     = (!word_format && !linear_mode) ? KIND_RETRY : KIND_CSUM;
          end
        end
        PH_LINE, PH_TAIL: begin
          phase_next = PH_LINE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LINE;
      high_nibble <= '0;
      toggle      <= 1'b0;
      running_sum <= '0;
      rec_len     <= '0;
      rec_off     <= '0;
      field_index <= '0;
      page_bits   <= '0;
      linear_mode <= 1'b0;
      total_bytes <= '0;
      stopped     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (q_pop) begin
        phase       <= phase_next;
        high_nibble <= high_nibble_next;
        toggle      <= toggle_next;
        running_sum <= running_sum_next;
        rec_len     <= rec_len_next;
        rec_off     <= rec_off_next;
        field_index <= field_index_next;
        page_bits   <= page_bits_next;
        linear_mode <= linear_mode_next;
        total_bytes <= total_bytes_next;
        stopped     <= stopped_next;
      end
      if (q_pop) begin
        out_valid <= res_fire;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res_fire) begin
      out_res <= res;
    end
  end

endmodule

### hw/rtl/intel_hex_record_parser_core.sv
// Top level of the hex record parser: front, queue, back and config register.
`timescale 1ns / 1ps

// Hex record parser core.
// Slave stream: one file character per transfer, tdata = character,
//   tuser[0] = restart (returns the parser to file start, character dropped).
// Master stream: one result per transfer, tuser = kind, tdata carries
//   address, data byte and running byte count. Each data byte of a record
//   gives a write transfer; each finished record gives one status transfer.
// Config channel: cfg_valid/cfg_ready/cfg_data writes word_format; write
//   only while the parser is idle. cfg_ready is always high.
// Throughput: one character per cycle sustained while the master side does not
//   stall. The front classifies and decodes the nibble in the accept cycle and
//   pushes into a small queue; the back state machine takes one queued character
//   per cycle unless a result waits on m_tready. An accepted character is written
//   into the queue, then the back registers its result in the output register.
// Stall: while a result waits on m_tready the back holds; the queue keeps
//   taking characters until it is full, then s_tready drops.
// Reset: rst (synchronous) empties the queue and output register, clears
//   all parse state and sets word_format to 0.
module intel_hex_record_parser_core #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // character, bits 7:0
  input  logic [7:0]  s_tdata,
  // restart, bit 0
  input  logic [0:0]  s_tuser,
  input  logic        s_tvalid,
  output logic        s_tready,
  // address 31:0, data 39:32, byte_count 71:40
  output logic [71:0] m_tdata,
  // kind, bits 2:0
  output logic [2:0]  m_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_data
);
  import ihex_pkg::*;

  logic    word_format;
  logic    q_push, q_full, q_pop, q_empty;
  item_t   q_in, q_head;
  result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_format <= 1'b0;
    end else if (cfg_valid) begin
      word_format <= cfg_data[0];
    end
  end

  ihex_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  ihex_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  ihex_back u_back (
    .clk         (clk),
    .rst         (rst),
    .word_format (word_format),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_res     (res)
  );

  assign m_tuser = res.kind;
  assign m_tdata = {res.byte_count, res.data, res.address};

  // queue never overflows or underflows
  assert property (@(posedge clk) disable iff (rst) !(q_push && q_full))
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst) !(q_pop && q_empty))
    else $error("pop from empty queue");
  // back must not overwrite a result the sink has not taken
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !q_pop)
    else $error("back advanced while output stalled");
  // status results carry zero address and data
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != KIND_WRITE) |-> (m_tdata[39:0] == 40'd0))
    else $error("status result with nonzero address or data");

endmodule

### tb/tb_intel_hex_record_parser_core.sv
// Self-checking testbench for the hex record parser core: directed table, then random files.
`timescale 1ns / 1ps

module tb_intel_hex_record_parser_core;
  import ihex_pkg::*;

  // One row of the directed table; typed rows carry their own expected result
  typedef struct packed {
    logic [7:0] ch;
    logic       rs;
    logic       typed;
    result_t    want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [7:0]  s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_data = '0;

  intel_hex_record_parser_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // Parser state mirrored by the predictor
  logic        word_mode = 1'b0;
  phase_t      ps_phase = PH_LINE;
  logic [7:0]  ps_hi = '0;
  logic        ps_odd = 1'b0;
  logic [7:0]  ps_sum = '0;
  logic [8:0]  ps_len = '0;
  logic [16:0] ps_off = '0;
  logic [8:0]  ps_idx = '0;
  logic [15:0] ps_page = '0;
  logic        ps_linear = 1'b0;
  logic [31:0] ps_total = '0;
  logic        ps_halt = 1'b0;

  result_t     pending_results[$];
  logic [8:0]  line_chars[$];   // {restart, character}
  logic [7:0]  line_sum;

  int tx_idle = 0;
  int rx_idle = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int chars_sent = 0;
  int chars_parsed = 0;
  int results_checked = 0;
  int writes_seen = 0;
  int errors = 0;

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    if (c <= CHAR_NINE) begin
      return c - CHAR_ZERO;
    end
    return (c & CASE_MASK) - CHAR_ALPHA;
  endfunction

  // Advance the mirrored parser by one character; returns 1 when a result is due
  function automatic bit parse_char(input logic [7:0] c, input logic rs, output result_t res);
    logic [7:0]  b;
    logic [31:0] off;
    res = '0;
    if (rs) begin
      ps_phase = PH_LINE;
      ps_hi = '0;
      ps_odd = 1'b0;
      ps_sum = '0;
      ps_len = '0;
      ps_off = '0;
      ps_idx = '0;
      ps_page = '0;
      ps_linear = 1'b0;
      ps_total = '0;
      ps_halt = 1'b0;
      return 1'b0;
    end
    if (ps_halt) begin
      return 1'b0;
    end
    chars_parsed++;
    res.byte_count = ps_total;
    if (c == CHAR_NEWLINE) begin
      if (ps_phase == PH_LINE || ps_phase == PH_TAIL) begin
        ps_phase = PH_LINE;
        return 1'b0;
      end
      ps_halt = 1'b1;
      res.kind = KIND_FORMAT;
      return 1'b1;
    end
    if (ps_phase == PH_LINE) begin
      // first character of a line is skipped whatever it is
      ps_phase = PH_LEN;
      ps_sum = '0;
      ps_odd = 1'b0;
      return 1'b0;
    end
    if (ps_phase == PH_TAIL) begin
      return 1'b0;
    end
    if (!ps_odd) begin
      ps_hi = digit_value(c) << 4;
      ps_odd = 1'b1;
      return 1'b0;
    end
    ps_odd = 1'b0;
    b = ps_hi | digit_value(c);
    ps_sum = ps_sum + b;
    case (ps_phase)
      PH_LEN: begin
        if (b == 8'h00) begin
          ps_halt = 1'b1;
          res.kind = KIND_EOF;
          return 1'b1;
        end
        ps_len = {1'b0, b};
        ps_idx = '0;
        ps_phase = PH_ADDR;
      end
      PH_ADDR: begin
        if (ps_idx == 0) begin
          ps_off = {1'b0, b, 8'h00};
          ps_idx = 9'd1;
        end else begin
          ps_off = ps_off | {9'b0, b};
          if (word_mode) begin
            ps_off = ps_off << 1;
            ps_len = ps_len << 1;
          end
          ps_phase = PH_TYPE;
        end
      end
      PH_TYPE: begin
        ps_idx = '0;
        if (b == REC_TYPE_PAGE) begin
          if (word_mode) begin
            ps_halt = 1'b1;
            res.kind = KIND_FORMAT;
            return 1'b1;
          end
          ps_phase = PH_PAGE;
        end else begin
          ps_phase = PH_DATA;
        end
      end
      PH_PAGE: begin
        if (ps_idx == 0) begin
          ps_page = {b, 8'h00};
          ps_idx = 9'd1;
        end else begin
          ps_page = ps_page | {8'h00, b};
          ps_linear = 1'b1;
          ps_phase = PH_CSUM;
        end
      end
      PH_DATA: begin
        // offset plus index may run past 16 bits and lands on the page as is
        off = ({15'b0, ps_off} + {23'b0, ps_idx}) ^ {31'b0, word_mode};
        ps_total = ps_total + 32'd1;
        ps_idx = ps_idx + 9'd1;
        if (ps_idx >= ps_len) begin
          ps_phase = PH_CSUM;
        end
        res.kind = KIND_WRITE;
        res.address = {ps_page, 16'h0000} | off;
        res.data = b;
        res.byte_count = ps_total;
        return 1'b1;
      end
      PH_CSUM: begin
        ps_phase = PH_TAIL;
        if (ps_sum == 8'h00) begin
          res.kind = KIND_OK;
          return 1'b1;
        end
        ps_halt = 1'b1;
        res.kind = (!word_mode && !ps_linear) ? KIND_RETRY : KIND_CSUM;
        return 1'b1;
      end
      default: begin
        ps_phase = PH_LINE;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic script_row_t script_row(input logic [7:0] ch, input logic rs,
                                             input logic typed = 1'b0,
                                             input kind_t k = KIND_WRITE,
                                             input logic [31:0] a = '0,
                                             input logic [7:0] d = '0,
                                             input logic [31:0] n = '0);
    script_row_t r;
    r.ch = ch;
    r.rs = rs;
    r.typed = typed;
    r.want.kind = k;
    r.want.address = a;
    r.want.data = d;
    r.want.byte_count = n;
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) begin
      return 8'h30 + n;
    end
    return (lower ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == CHAR_NEWLINE);
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_char(input logic [7:0] c, input logic rs, input bit typed = 1'b0,
                           input result_t want = '0);
    result_t r;
    bit      due;
    while ($urandom_range(0, 99) < tx_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tuser <= rs;
    do @(posedge clk); while (!s_tready);
    chars_sent++;
    due = parse_char(c, rs, r);
    if (typed) begin
      pending_results.push_back(want);
    end else if (due) begin
      pending_results.push_back(r);
    end
    @(negedge clk);
  endtask

  // Lower valid, wait out every expected result, then the pipeline's idle tail
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (16) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_format(input logic v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    word_mode = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_byte(input logic [7:0] b);
    line_chars.push_back({1'b0, hex_char(b[7:4], 1'($urandom_range(0, 1)))});
    line_chars.push_back({1'b0, hex_char(b[3:0], 1'($urandom_range(0, 1)))});
    line_sum = line_sum + b;
  endtask

  // One record line, mostly well formed, sometimes cut short, corrupted or interrupted
  task automatic play_record();
    logic [7:0]  len;
    logic [7:0]  rtype;
    logic [7:0]  csum;
    logic [15:0] page;
    int          n;
    int          k;
    int          pick;
    line_chars.delete();
    line_sum = '0;
    if ($urandom_range(0, 99) < 5) begin
      line_chars.push_back({1'b0, CHAR_NEWLINE});
    end
    line_chars.push_back({1'b0, ($urandom_range(0, 9) == 0) ? text_char() : 8'h3A});
    len = ($urandom_range(0, 29) == 0) ? 8'($urandom_range(5, 255))
                                       : 8'($urandom_range(1, 4));
    pick = $urandom_range(0, 99);
    if (pick < 78) begin
      rtype = 8'h00;
    end else if (pick < 90) begin
      rtype = REC_TYPE_PAGE;
    end else begin
      rtype = 8'($urandom_range(0, 255));
    end
    add_byte(len);
    add_byte(8'($urandom_range(0, 255)));
    add_byte(8'($urandom_range(0, 255)));
    add_byte(rtype);
    if (rtype == REC_TYPE_PAGE) begin
      page = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom_range(0, 65535));
      add_byte(page[15:8]);
      add_byte(page[7:0]);
    end else begin
      n = word_mode ? 2 * len : len;
      repeat (n) add_byte(8'($urandom_range(0, 255)));
    end
    csum = -line_sum;
    if ($urandom_range(0, 99) < 10) begin
      csum = csum ^ 8'($urandom_range(1, 255));
    end
    add_byte(csum);
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 3)) line_chars.push_back({1'b0, text_char()});
    end
    line_chars.push_back({1'b0, CHAR_NEWLINE});
    pick = $urandom_range(0, 99);
    k = $urandom_range(1, line_chars.size() - 2);
    if (pick < 6) begin
      // line ends early
      line_chars = line_chars[0:k];
      line_chars[k] = {1'b0, CHAR_NEWLINE};
    end else if (pick < 11) begin
      line_chars[k] = {1'b0, text_char()};
    end else if (pick < 14) begin
      line_chars.insert(k, {1'b1, 8'($urandom_range(0, 255))});
    end
    foreach (line_chars[i]) begin
      send_char(line_chars[i][7:0], line_chars[i][8]);
    end
  endtask

  // Restart, a few records, usually an end-of-file record, sometimes junk after it
  task automatic play_file();
    send_char(8'($urandom_range(0, 255)), 1'b1);
    repeat ($urandom_range(1, 5)) play_record();
    if ($urandom_range(0, 4) != 0) begin
      line_chars.delete();
      line_chars.push_back({1'b0, 8'h3A});
      add_byte(8'h00);
      add_byte(8'h00);
      add_byte(8'h00);
      add_byte(8'h01);
      add_byte(8'hFF);
      line_chars.push_back({1'b0, CHAR_NEWLINE});
      foreach (line_chars[i]) begin
        send_char(line_chars[i][7:0], line_chars[i][8]);
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 80;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  // Result checker: every transfer against the oldest expectation
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_checked++;
      if (m_tuser == KIND_WRITE) begin
        writes_seen++;
      end
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d, tdata %h", m_tuser, m_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.kind) begin
          $error("kind mismatch: expected %0d, got %0d", want.kind, m_tuser);
          errors++;
        end
        if (m_tdata[31:0] !== want.address) begin
          $error("address mismatch: expected %h, got %h", want.address, m_tdata[31:0]);
          errors++;
        end
        if (m_tdata[39:32] !== want.data) begin
          $error("data mismatch: expected %h, got %h", want.data, m_tdata[39:32]);
          errors++;
        end
        if (m_tdata[71:40] !== want.byte_count) begin
          $error("byte_count mismatch: expected %0d, got %0d", want.byte_count,
                 m_tdata[71:40]);
          errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("intel_hex_record_parser_core verification failed");
    $finish;
  end

  initial begin : stimulus
    script_row_t directed[$];
    int          quota;
    bit          first;
    directed = '{
      script_row(8'h00, 1'b1),                      // restart, character dropped
      script_row(CHAR_NEWLINE, 1'b0),               // empty line
      script_row(":", 1'b0),
      script_row("0", 1'b0),
      script_row("0", 1'b0, 1'b1, KIND_EOF),        // zero length ends the file
      script_row("Z", 1'b0),                        // ignored once stopped
      script_row(8'hFF, 1'b1),
      script_row(":", 1'b0),
      script_row(CHAR_NEWLINE, 1'b0, 1'b1, KIND_FORMAT),  // short line
      script_row(8'hA5, 1'b1),
      script_row(":", 1'b0),
      script_row("0", 1'b0),
      script_row("1", 1'b0),
      script_row("f", 1'b0),                        // mixed case digits
      script_row("F", 1'b0),
      script_row("f", 1'b0),
      script_row("F", 1'b0),
      script_row("0", 1'b0),
      script_row("0", 1'b0),
      script_row("F", 1'b0),
      script_row("f", 1'b0, 1'b1, KIND_WRITE, 32'h0000_FFFF, 8'hFF, 32'd1),
      script_row("0", 1'b0),
      script_row("2", 1'b0, 1'b1, KIND_OK, 32'd0, 8'h00, 32'd1),
      script_row("x", 1'b0),                        // trailing text
      script_row(CHAR_NEWLINE, 1'b0)
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    tx_idle = 34;
    rx_idle = 52;
    write_format(1'b0);
    foreach (directed[i]) begin
      send_char(directed[i].ch, directed[i].rs, directed[i].typed, directed[i].want);
    end
    drain();

    // Six phases: three idle profiles, each with byte and word records
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          tx_idle = 34;
          rx_idle = 52;
        end
        1: begin
          tx_idle = 52;
          rx_idle = 34;
        end
        default: begin
          tx_idle = 0;
          rx_idle = 0;
        end
      endcase
      write_format(1'(ph % 2));
      quota = chars_sent + 250;
      first = 1'b1;
      while (chars_sent < quota) begin
        if (ph == 0 && first) begin
          hold_req = 1'b1;   // receiver backs off so the queue fills up
        end
        play_file();
        if (ph == 3 && first) begin
          drain();           // sender pauses until the output side catches up
        end
        first = 1'b0;
      end
      drain();
    end

    $display("Covered %0d characters sent (%0d parsed), %0d results checked (%0d data writes),",
             chars_sent, chars_parsed, results_checked, writes_seen);
    $display("byte and word formats, page records, errors and restarts, three idle profiles.");
    if (errors == 0) begin
      $display("intel_hex_record_parser_core verification clean");
    end else begin
      $display("intel_hex_record_parser_core verification failed");
    end
    $finish;
  end

endmodule
